// ===== rtl/core/kslp_pkg.sv =====
// ----------------------------------------------------------------------------
// kslp_pkg
// Shared types and constants for the key scan long-press detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kslp_pkg;

    localparam int NUM_KEYS  = 24;
    localparam int TIME_BITS = 32;
    localparam int HOLD_W    = 16;
    localparam int KEY_IDX_W = 5;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_TIMING = 2'd1,
        MODE_DONE   = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_WALK  = 2'd1,
        S_FLUSH = 2'd2
    } t_state;

    // Event raised by the key unit for the key under the walk pointer
    typedef struct packed {
        logic ev;
        logic long_press;
    } t_key_res;

endpackage

// ===== rtl/core/key_scan_long_press_detector_top.sv =====
// ----------------------------------------------------------------------------
// key_scan_long_press_detector_top
// Results: events found during the key walk leave during the walk; the last
// result of a scan, marked with tlast, is registered in the flush state that
// follows the walk, later if the output stalls. One key is visited per cycle
// through the shared deadline adder while the output does not stall; a new
// scan is taken only in the idle state. Synchronous active-low reset sets every
// key idle, empties the output and restores the hold time to 60 ticks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module key_scan_long_press_detector_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: long_press_ticks
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    // input scan stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [55:0] i_s_tdata,  // [23:0] key_levels, [55:24] now_ticks
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,  // [4:0] key_index, [5] long_press,
                                    // [6] any_pressed, [7] zero
    output logic        o_m_tuser,  // [0] event_valid
    output logic        o_m_tlast   // last_of_scan
);
    import kslp_pkg::*;

    t_state                r_state;
    t_state                n_state;
    logic [HOLD_W-1:0]     r_hold;
    logic [NUM_KEYS-1:0]   r_levels;
    logic [TIME_BITS-1:0]  r_now;
    logic                  r_any;
    logic [KEY_IDX_W-1:0]  r_idx;

    // one pending event, held back until it is known whether it is the last
    logic                  r_pend_valid;
    logic [KEY_IDX_W-1:0]  r_pend_idx;
    logic                  r_pend_long;

    logic                  r_ovalid;
    logic                  r_oev;
    logic [KEY_IDX_W-1:0]  r_oidx;
    logic                  r_olong;
    logic                  r_oany;
    logic                  r_olast;

    logic                  accept;
    logic                  out_free;
    logic                  step;
    logic                  flush;
    logic                  last_key;
    t_key_res              key_res;

    assign accept   = i_s_tvalid && o_s_tready;
    assign out_free = !r_ovalid || i_m_tready;
    assign last_key = (r_idx == KEY_IDX_W'(NUM_KEYS - 1));

    kslp_key_unit u_key_unit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_idx     (r_idx),
        .i_pressed (!r_levels[r_idx]),
        .i_now     (r_now),
        .i_hold    (r_hold),
        .o_res     (key_res)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_WALK;
            end
            S_WALK: begin
                if (step && last_key) n_state = S_FLUSH;
            end
            S_FLUSH: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_s_tready = 1'b0;
        step       = 1'b0;
        flush      = 1'b0;
        case (r_state)
            S_IDLE:  o_s_tready = 1'b1;
            // hold the walk when a second event has nowhere to go
            S_WALK:  step  = !(key_res.ev && r_pend_valid && !out_free);
            S_FLUSH: flush = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_hold       <= HOLD_W'(60);
            r_idx        <= '0;
            r_pend_valid <= 1'b0;
            r_ovalid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_hold <= i_cfg_wdata;
            if (accept) r_idx <= '0;
            else if (step) r_idx <= r_idx + KEY_IDX_W'(1);

            if ((step && key_res.ev && r_pend_valid) || flush) begin
                r_ovalid <= 1'b1;
            end else if (o_m_tvalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end

            if (step && key_res.ev) begin
                r_pend_valid <= 1'b1;
            end
            if (flush) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_levels <= i_s_tdata[NUM_KEYS-1:0];
            r_now    <= i_s_tdata[24 +: TIME_BITS];
            r_any    <= ~&i_s_tdata[NUM_KEYS-1:0];
        end
        if (step && key_res.ev) begin
            r_pend_idx  <= r_idx;
            r_pend_long <= key_res.long_press;
            if (r_pend_valid) begin
                r_oev   <= 1'b1;
                r_oidx  <= r_pend_idx;
                r_olong <= r_pend_long;
                r_oany  <= r_any;
                r_olast <= 1'b0;
            end
        end
        if (flush) begin
            r_oev   <= r_pend_valid;
            r_oidx  <= r_pend_valid ? r_pend_idx : '0;
            r_olong <= r_pend_valid && r_pend_long;
            r_oany  <= r_any;
            r_olast <= 1'b1;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {1'b0, r_oany, r_olong, r_oidx};
    assign o_m_tuser  = r_oev;
    assign o_m_tlast  = r_olast;

endmodule

// ===== rtl/core/kslp_key_unit.sv =====
// ----------------------------------------------------------------------------
// kslp_key_unit
// Per-key mode and deadline store with one shared add/subtract unit that
// either forms a new deadline or tests the stored one against the time stamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kslp_key_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [kslp_pkg::KEY_IDX_W-1:0] i_idx,
    input  logic                          i_pressed,
    input  logic [kslp_pkg::TIME_BITS-1:0] i_now,
    input  logic [kslp_pkg::HOLD_W-1:0]    i_hold,
    output kslp_pkg::t_key_res            o_res
);
    import kslp_pkg::*;

    t_mode                r_mode [NUM_KEYS];
    logic [TIME_BITS-1:0] r_deadline [NUM_KEYS];

    t_mode                cur_mode;
    t_mode                n_mode;
    logic [TIME_BITS-1:0] cur_deadline;
    logic [TIME_BITS-1:0] op_a;
    logic [TIME_BITS-1:0] op_b;
    logic [TIME_BITS-1:0] sum;
    logic                 is_timing;
    logic                 past;
    logic                 write_dl;

    assign cur_mode     = r_mode[i_idx];
    assign cur_deadline = r_deadline[i_idx];
    assign is_timing    = (cur_mode == MODE_TIMING);

    // Shared adder: deadline - now while timing, now + hold otherwise
    assign op_a = is_timing ? cur_deadline : i_now;
    assign op_b = is_timing ? ~i_now : TIME_BITS'(i_hold);
    assign sum  = op_a + op_b + TIME_BITS'(is_timing);
    assign past = sum[TIME_BITS-1];

    always_comb begin
        n_mode           = MODE_IDLE;
        write_dl         = 1'b0;
        o_res.ev         = 1'b0;
        o_res.long_press = 1'b0;
        case (cur_mode)
            MODE_TIMING: begin
                if (i_pressed) begin
                    if (past) begin
                        o_res.ev         = 1'b1;
                        o_res.long_press = 1'b1;
                        n_mode           = MODE_DONE;
                    end else begin
                        n_mode = MODE_TIMING;
                    end
                end else begin
                    o_res.ev         = 1'b1;
                    o_res.long_press = past;
                end
            end
            MODE_DONE: begin
                n_mode = i_pressed ? MODE_DONE : MODE_IDLE;
            end
            default: begin
                // unused code behaves as idle
                if (i_pressed) begin
                    n_mode   = MODE_TIMING;
                    write_dl = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_mode[k] <= MODE_IDLE;
            end
        end else if (i_step) begin
            r_mode[i_idx] <= n_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && write_dl) begin
            r_deadline[i_idx] <= sum;
        end
    end

endmodule
